@@ design/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Polygon convexity check package
// Shared constants, types and the side-value arithmetic for the convexity
// checker.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // Coordinate width of one vertex component.
  localparam int unsigned CoordWidth = 16;

  // Stream word widths, rounded up to whole bytes.
  localparam int unsigned InDataWidth  = ((2 * CoordWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = 8;

  // Widths of the side-value arithmetic.
  localparam int unsigned DiffWidth = CoordWidth + 1;
  localparam int unsigned ProdWidth = 2 * CoordWidth + 2;
  localparam int unsigned SideWidth = 2 * CoordWidth + 3;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } vertex_t;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_e;

  typedef struct packed {
    sign_e ref_sign;
    logic  violation;
  } verdict_t;

  // Sign of (u - p) x (q - p).
  function automatic sign_e side_sign(vertex_t p, vertex_t q, vertex_t u);
    logic signed [DiffWidth-1:0] ax;
    logic signed [DiffWidth-1:0] ay;
    logic signed [DiffWidth-1:0] bx;
    logic signed [DiffWidth-1:0] by;
    logic signed [ProdWidth-1:0] prod_a;
    logic signed [ProdWidth-1:0] prod_b;
    logic signed [SideWidth-1:0] side;
    sign_e                       result;
    ax     = DiffWidth'(coord_t'(u.x)) - DiffWidth'(coord_t'(p.x));
    ay     = DiffWidth'(coord_t'(u.y)) - DiffWidth'(coord_t'(p.y));
    bx     = DiffWidth'(coord_t'(q.x)) - DiffWidth'(coord_t'(p.x));
    by     = DiffWidth'(coord_t'(q.y)) - DiffWidth'(coord_t'(p.y));
    prod_a = ProdWidth'(ax) * ProdWidth'(by);
    prod_b = ProdWidth'(ay) * ProdWidth'(bx);
    side   = SideWidth'(prod_a) - SideWidth'(prod_b);
    if (side == '0) begin
      result = SIGN_NONE;
    end else if (side[SideWidth-1]) begin
      result = SIGN_NEG;
    end else begin
      result = SIGN_POS;
    end
    return result;
  endfunction

  // Fold one side sign into the running verdict.
  function automatic verdict_t fold_sign(verdict_t v, sign_e s);
    verdict_t r;
    r = v;
    if (s != SIGN_NONE) begin
      if (v.ref_sign == SIGN_NONE) begin
        r.ref_sign = s;
      end else if (v.ref_sign != s) begin
        r.violation = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

@@ design/polygon_convexity_check.sv @@
// ----------------------------------------------------------------------------
// Polygon convexity check
// Streams polygon vertices and reports whether the polygon is convex.
// ----------------------------------------------------------------------------
// Throughput: one vertex word per cycle; a last vertex waits only while the
//   previous result word is still held back by the master side.
// Result path: the last vertex goes from the input register to the result
//   register, and the result word is held there until it is taken.
// The last vertex evaluates three side values in parallel multipliers.
// Reset (rst_ni low) clears all control state; the block is ready at once.
// ----------------------------------------------------------------------------
module polygon_convexity_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // Fields from bit 0 up: point_x, point_y.
  input  logic [pcc_pkg::InDataWidth-1:0]   s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // Fields from bit 0 up: is_convex, too_few_points, then zero padding.
  output logic [pcc_pkg::OutDataWidth-1:0]  m_axis_tdata_o
);
  import pcc_pkg::*;

  // Input register: one vertex word waiting to be processed.
  logic     in_valid_q, in_valid_d;
  logic     in_last_q;
  vertex_t  in_vtx_q;

  // Polygon state. The vertex stores need no reset: each is written before
  // it is ever read within a polygon.
  vertex_t  first_q, second_q, older_q, newer_q;
  logic [1:0] count_q, count_d;
  verdict_t verdict_q, verdict_d;

  // Result register.
  logic     out_valid_q, out_valid_d;
  logic     is_convex_q, is_convex_d;
  logic     too_few_q, too_few_d;

  logic     in_accept;
  logic     process;
  logic     enough;
  sign_e    side_a, side_b, side_c;
  verdict_t verdict_a, verdict_b, verdict_c;

  // The vertex in the input register is processed when it needs no result
  // slot, or when the result register is empty or being drained this cycle.
  assign process = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);

  // A new word may enter whenever the input register empties this cycle, so
  // vertices flow back to back even while a result waits on the master side.
  assign s_axis_tready_o = !in_valid_q || process;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // At least two earlier vertices are held, so the side values are defined.
  assign enough = count_q[1];

  // The running triple, then the two triples that wrap round to the start.
  always_comb begin
    side_a = side_sign(older_q, newer_q, in_vtx_q);
    side_b = side_sign(newer_q, in_vtx_q, first_q);
    side_c = side_sign(in_vtx_q, first_q, second_q);
    verdict_a = enough ? fold_sign(verdict_q, side_a) : verdict_q;
    verdict_b = fold_sign(verdict_a, side_b);
    verdict_c = fold_sign(verdict_b, side_c);
  end

  // Next state of the control registers and the result.
  always_comb begin
    in_valid_d  = in_accept || (in_valid_q && !process);
    count_d     = count_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    is_convex_d = is_convex_q;
    too_few_d   = too_few_q;
    if (process) begin
      if (in_last_q) begin
        // Close the polygon, deliver the verdict and start afresh.
        count_d     = 2'd0;
        verdict_d   = '{ref_sign: SIGN_NONE, violation: 1'b0};
        out_valid_d = 1'b1;
        is_convex_d = enough && !verdict_c.violation;
        too_few_d   = !enough;
      end else begin
        verdict_d = verdict_a;
        if (count_q != 2'd3) begin
          count_d = count_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      count_q     <= 2'd0;
      verdict_q   <= '{ref_sign: SIGN_NONE, violation: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      count_q     <= count_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_vtx_q.x <= coord_t'(s_axis_tdata_i[CoordWidth-1:0]);
      in_vtx_q.y <= coord_t'(s_axis_tdata_i[2*CoordWidth-1:CoordWidth]);
      in_last_q  <= s_axis_tlast_i;
    end
    if (process) begin
      if (count_q == 2'd0) begin
        first_q <= in_vtx_q;
      end
      if (count_q == 2'd1) begin
        second_q <= in_vtx_q;
      end
      older_q <= newer_q;
      newer_q <= in_vtx_q;
    end
    is_convex_q <= is_convex_d;
    too_few_q   <= too_few_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataWidth'({too_few_q, is_convex_q});

`ifndef SYNTHESIS
  // A polygon cannot be both convex and too short.
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(is_convex_q && too_few_q))
    else $error("convex and too-few flags both set");

  // Closing a polygon returns the state to its start.
  a_state_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_last_q) |=>
      (count_q == 2'd0 && verdict_q.ref_sign == SIGN_NONE && !verdict_q.violation))
    else $error("polygon state not cleared after last vertex");

  // A violation can only be flagged against an established reference sign.
  a_violation_has_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_q.violation |-> verdict_q.ref_sign != SIGN_NONE)
    else $error("violation without reference sign");

  // A held vertex is only ever stalled by a full, blocked result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !process) |-> (in_last_q && out_valid_q && !m_axis_tready_i))
    else $error("vertex stalled without output back-pressure");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Polygon convexity check testbench
// Streams polygons into the checker with bursty input and a stalling
// receiver. A scoreboard works out the verdict for every polygon from the
// accepted vertex words and compares it with each result word.
// ----------------------------------------------------------------------------
module testbench;

  import pcc_pkg::*;

  // Generous bound on the run length, in clock cycles.
  localparam int unsigned CycleLimit = 400000;
  // Random vertices to send after the directed polygons.
  localparam int unsigned RandomVertices = 1950;

  typedef struct {
    bit is_convex;
    bit too_few;
  } outcome_t;

  // Keeps its own copy of the checker state and predicts one outcome per
  // polygon. Expected outcomes wait in order until their result word comes.
  class convexity_scoreboard;
    int       first_x, first_y, second_x, second_y;
    int       older_x, older_y, newer_x, newer_y;
    int       seen;
    sign_e    ref_sign;
    bit       broken;
    outcome_t expected_q[$];
    int       errors;
    int       vertices;
    int       polygons;
    int       convex_cnt;
    int       concave_cnt;
    int       too_few_cnt;

    function new();
      errors      = 0;
      vertices    = 0;
      polygons    = 0;
      convex_cnt  = 0;
      concave_cnt = 0;
      too_few_cnt = 0;
      clear_polygon();
    endfunction

    function void clear_polygon();
      first_x  = 0;
      first_y  = 0;
      second_x = 0;
      second_y = 0;
      older_x  = 0;
      older_y  = 0;
      newer_x  = 0;
      newer_y  = 0;
      seen     = 0;
      ref_sign = SIGN_NONE;
      broken   = 1'b0;
    endfunction

    // Sign of (u - p) x (q - p), worked out in 64 bits so nothing overflows.
    function sign_e turn_sign(int px, int py, int qx, int qy, int ux, int uy);
      longint side;
      side = (longint'(ux) - px) * (longint'(qy) - py)
           - (longint'(uy) - py) * (longint'(qx) - px);
      if (side > 0) begin
        return SIGN_POS;
      end else if (side < 0) begin
        return SIGN_NEG;
      end
      return SIGN_NONE;
    endfunction

    // The first nonzero turn sets the reference; any opposite turn breaks it.
    function void fold_turn(int px, int py, int qx, int qy, int ux, int uy);
      sign_e s;
      s = turn_sign(px, py, qx, qy, ux, uy);
      if (s != SIGN_NONE) begin
        if (ref_sign == SIGN_NONE) begin
          ref_sign = s;
        end else if (ref_sign != s) begin
          broken = 1'b1;
        end
      end
    endfunction

    function void note_vertex(logic [InDataWidth-1:0] word, logic last);
      int       cx, cy;
      outcome_t o;
      cx = int'(coord_t'(word[CoordWidth-1:0]));
      cy = int'(coord_t'(word[2*CoordWidth-1:CoordWidth]));
      vertices++;
      if (seen >= 2) begin
        fold_turn(older_x, older_y, newer_x, newer_y, cx, cy);
      end
      if (seen == 0) begin
        first_x = cx;
        first_y = cy;
      end else if (seen == 1) begin
        second_x = cx;
        second_y = cy;
      end
      if (!last) begin
        older_x = newer_x;
        older_y = newer_y;
        newer_x = cx;
        newer_y = cy;
        if (seen < 3) begin
          seen++;
        end
      end else begin
        // Close the polygon with the two wrap-around triples.
        if (seen >= 2) begin
          fold_turn(newer_x, newer_y, cx, cy, first_x, first_y);
          fold_turn(cx, cy, first_x, first_y, second_x, second_y);
          o.is_convex = !broken;
          o.too_few   = 1'b0;
        end else begin
          o.is_convex = 1'b0;
          o.too_few   = 1'b1;
        end
        expected_q.push_back(o);
        polygons++;
        if (o.too_few) begin
          too_few_cnt++;
        end else if (o.is_convex) begin
          convex_cnt++;
        end else begin
          concave_cnt++;
        end
        clear_polygon();
      end
    endfunction

    function void check_result(logic [OutDataWidth-1:0] word);
      outcome_t o;
      if (expected_q.size() == 0) begin
        $display("%0t: result word %h arrived with no polygon outstanding", $time, word);
        errors++;
        return;
      end
      o = expected_q.pop_front();
      if (word[0] !== o.is_convex) begin
        $display("%0t: is_convex mismatch, expected %0b, actual %0b",
                 $time, o.is_convex, word[0]);
        errors++;
      end
      if (word[1] !== o.too_few) begin
        $display("%0t: too_few_points mismatch, expected %0b, actual %0b",
                 $time, o.too_few, word[1]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_valid = 1'b0;
  logic                    s_ready;
  logic [InDataWidth-1:0]  s_data = '0;
  logic                    s_last = 1'b0;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [OutDataWidth-1:0] m_data;

  int unsigned cycles = 0;
  int unsigned ready_mode = 0;

  // Vertices of the polygon being built, sent as one run by send_polygon.
  int poly_x[$];
  int poly_y[$];
  // Centre of the last convex polygon built, used to dent it.
  int centre_x, centre_y;
  // Items left in the current input burst.
  int burst_left = 8;

  convexity_scoreboard sb = new();

  polygon_convexity_check u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // Fields from bit 0 up: point_x, point_y.
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)    // Fields from bit 0 up: is_convex, too_few_points.
  );

  always #6 clk_i = ~clk_i;

  // Values read here are those seen by the block at this edge, since every
  // driver and the block itself update through nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        sb.note_vertex(s_data, s_last);
      end
      if (m_valid && m_ready) begin
        sb.check_result(m_data);
      end
    end
  end

  // The receiver switches at intervals among four manners: always ready, a coin
  // toss, mostly stalled, or a regular on-off pattern.
  always @(posedge clk_i) begin
    logic r;
    if (cycles % 64 == 0) begin
      ready_mode = $urandom_range(0, 3);
    end
    case (ready_mode)
      0: begin
        r = 1'b1;
      end
      1: begin
        r = $urandom_range(0, 1) == 1;
      end
      2: begin
        r = $urandom_range(0, 5) == 0;
      end
      default: begin
        r = cycles[2];
      end
    endcase
    m_ready <= r;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Cycle limit reached with %0d results outstanding", sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_point(input int x, input int y);
    poly_x.push_back(x);
    poly_y.push_back(y);
  endtask

  // Present one vertex word and hold it until the block takes it.
  task automatic send_vertex(input int x, input int y, input logic last);
    s_valid <= 1'b1;
    s_data  <= {CoordWidth'(y), CoordWidth'(x)};
    s_last  <= last;
    @(posedge clk_i);
    while (!s_ready) begin
      @(posedge clk_i);
    end
  endtask

  // Send the built polygon; bursts end at random, even within a polygon,
  // and a gap of zero keeps valid high.
  task automatic send_polygon();
    int gap;
    for (int k = 0; k < poly_x.size(); k++) begin
      send_vertex(poly_x[k], poly_y[k], k == poly_x.size() - 1);
      burst_left--;
      if (burst_left <= 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
      end
    end
    poly_x.delete();
    poly_y.delete();
  endtask

  // Roughly regular polygon on a circle, in either winding. Small radii make
  // rounding produce collinear and slightly broken shapes as well.
  task automatic build_convex(input int n);
    real w [16];
    real total, ang, rad;
    int  dir;
    centre_x = $urandom_range(0, 32766) - 16383;
    centre_y = $urandom_range(0, 32766) - 16383;
    rad   = ($urandom_range(0, 3) == 0) ? real'($urandom_range(1, 40))
                                        : real'($urandom_range(41, 16383));
    dir   = $urandom_range(0, 1) ? 1 : -1;
    total = 0.0;
    for (int k = 0; k < n; k++) begin
      w[k]  = 0.5 + real'($urandom_range(0, 1000)) / 1000.0;
      total = total + w[k];
    end
    ang = real'($urandom_range(0, 6283)) / 1000.0;
    for (int k = 0; k < n; k++) begin
      add_point(centre_x + $rtoi(rad * $cos(ang)), centre_y + $rtoi(rad * $sin(ang)));
      ang = ang + dir * 6.2831853 * w[k] / total;
    end
  endtask

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic build_random_polygon();
    int n, dx, dy, bx, by, idx, w, h;
    case ($urandom_range(0, 9))
      0, 1: begin
        // Unstructured vertices over the whole coordinate range.
        n = $urandom_range(1, 8);
        repeat (n) add_point($urandom_range(0, 65535) - 32768,
                             $urandom_range(0, 65535) - 32768);
      end
      2, 3, 4, 5: begin
        build_convex($urandom_range(3, 12));
      end
      6: begin
        // Convex outline with one vertex pulled in to the centre.
        build_convex($urandom_range(4, 10));
        idx = $urandom_range(0, poly_x.size() - 1);
        poly_x[idx] = centre_x;
        poly_y[idx] = centre_y;
      end
      7: begin
        n = $urandom_range(1, 6);
        repeat (n) add_point(extreme_coord(), extreme_coord());
      end
      8: begin
        // Points on one line, repeats allowed, so every turn is zero.
        n  = $urandom_range(2, 8);
        bx = $urandom_range(0, 2000) - 1000;
        by = $urandom_range(0, 2000) - 1000;
        dx = $urandom_range(0, 200) - 100;
        dy = $urandom_range(0, 200) - 100;
        for (int k = 0; k < n; k++) begin
          idx = $urandom_range(0, 100) - 50;
          add_point(bx + idx * dx, by + idx * dy);
        end
      end
      default: begin
        // Axis-aligned rectangle, either winding, up to the full range.
        bx = $urandom_range(0, 32767) - 32768;
        by = $urandom_range(0, 32767) - 32768;
        w  = $urandom_range(0, 65535 - (bx + 32768));
        h  = $urandom_range(0, 65535 - (by + 32768));
        if ($urandom_range(0, 1)) begin
          add_point(bx, by);
          add_point(bx + w, by);
          add_point(bx + w, by + h);
          add_point(bx, by + h);
        end else begin
          add_point(bx, by);
          add_point(bx, by + h);
          add_point(bx + w, by + h);
          add_point(bx + w, by);
        end
      end
    endcase
  endtask

  initial begin
    int sent;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A lone vertex, then a pair at opposite corners: both too few.
    add_point(0, 0);
    send_polygon();
    add_point(-32768, -32768);
    add_point(32767, 32767);
    send_polygon();
    // Small triangle wound one way, then the largest triangle the other way.
    add_point(0, 0);
    add_point(10, 0);
    add_point(0, 10);
    send_polygon();
    add_point(-32768, -32768);
    add_point(-32768, 32767);
    add_point(32767, -32768);
    send_polygon();
    // Collinear vertices never set a sign and count as convex.
    add_point(0, 0);
    add_point(1, 1);
    add_point(2, 2);
    add_point(3, 3);
    send_polygon();
    // The first turn is zero, so the reference comes from a later one.
    add_point(0, 0);
    add_point(1, 0);
    add_point(2, 0);
    add_point(2, 2);
    add_point(0, 2);
    send_polygon();
    // A dented quadrilateral.
    add_point(0, 0);
    add_point(10, 0);
    add_point(2, 2);
    add_point(0, 10);
    send_polygon();
    // Three copies of one point.
    add_point(5, 5);
    add_point(5, 5);
    add_point(5, 5);
    send_polygon();

    sent = 0;
    while (sent < RandomVertices) begin
      build_random_polygon();
      sent += poly_x.size();
      send_polygon();
    end
    s_valid <= 1'b0;
    s_last  <= 1'b0;
    // Let the monitor note the final vertex before counting what is pending.
    @(posedge clk_i);

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    // Keep the clock running afterwards to catch any stray result word.
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("Run covered %0d polygons over %0d vertices in %0d cycles.",
             sb.polygons, sb.vertices, cycles);
    $display("Verdicts: %0d convex, %0d not convex, %0d with too few vertices.",
             sb.convex_cnt, sb.concave_cnt, sb.too_few_cnt);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
